// File: src/tlpq_pkg.sv
package tlpq_pkg;

  // default sizes
  localparam int DEF_SLOT_COUNT  = 64;
  localparam int DEF_DATA_WIDTH  = 32;
  localparam int DEF_LEVEL_COUNT = 3;

  // fixed stream widths
  localparam int WORD_W      = 32;
  localparam int PRIO_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 4;

  // operation codes
  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    CTRL_IDLE   = 1'b0,
    CTRL_COMMIT = 1'b1
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic commit;
  } tlpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } tlpq_stat_t;

endpackage

// File: src/three_level_priority_queue_core.sv
// Strict priority queue: LEVEL_COUNT levels (level 1 highest) sharing a pool of SLOT_COUNT
// linked slots; order within a level is first in, first out.
// Input channel s_*: one beat is one operation. s_tuser selects enqueue (0) or dequeue (1);
// s_tdata carries the level and the data word to enqueue.
// Output channel m_*: exactly one result beat per operation, in order. m_tdata is the
// dequeued word (zero otherwise); m_tuser holds out_valid, status and queue_empty.
// Dequeue while empty and enqueue while full are reported in status and change nothing.
// The result is registered in the output register at the update that follows the accept
// of the input beat, once the output register is free.
// The list, payload and free-slot memories have a registered read, so each operation has a
// read step and then an update step; a new beat is not accepted before that update is done.
// Only one operation is in flight at a time.
// Reset (rst, synchronous) empties all levels and returns every slot to the pool; no
// clearing pass is needed, so the block accepts a beat as soon as reset is released.
// When m_tready is low, the finished result waits in the output register; the next beat
// is still accepted and read, and its update waits until the output register is free.
module three_level_priority_queue_core import tlpq_pkg::*; #(
  parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
  parameter int LEVEL_COUNT = DEF_LEVEL_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [1:0] priority_level, [33:2] data_word, [39:34] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [0] mode
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [31:0] out_data
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // [0] out_valid, [2:1] status, [3] queue_empty
  output logic [OUT_TUSER_W-1:0] m_tuser
);

  tlpq_cmd_t  cmd;
  tlpq_stat_t stat;

  // sequencing
  tlpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // lists, pool and result register
  tlpq_datapath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .DATA_WIDTH  (DATA_WIDTH),
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_user   (s_tuser),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

`ifndef SYNTHESIS
  // one operation in flight: no new beat in the cycle after an accept
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("beat accepted while an operation is in flight");

  // an update never coincides with taking a new beat
  assert property (@(posedge clk) disable iff (rst) !(cmd.commit && s_tready))
    else $error("commit while accepting");

  // a failed enqueue never carries data
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[2:1] == ST_FULL)) |-> (!m_tuser[0] && (m_tdata == '0)))
    else $error("full result carries data");

  // a dequeue on an empty queue leaves it empty
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[2:1] == ST_EMPTY)) |-> (m_tuser[3] && !m_tuser[0]))
    else $error("empty result inconsistent");
`endif

endmodule

// File: src/tlpq_ram.sv
module tlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/tlpq_ctrl.sv
module tlpq_ctrl import tlpq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  tlpq_stat_t stat,
  output tlpq_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTRL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      CTRL_IDLE: begin
        // no beat is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.latch  = 1'b1;
          state_next = CTRL_COMMIT;
        end
      end
      CTRL_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = CTRL_IDLE;
        end
      end
      default: begin
        state_next = CTRL_IDLE;
      end
    endcase
  end

endmodule

// File: src/tlpq_datapath.sv
module tlpq_datapath import tlpq_pkg::*; #(
  parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
  parameter int LEVEL_COUNT = DEF_LEVEL_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tlpq_cmd_t              cmd,
  output tlpq_stat_t             stat,
  input  logic [IN_TUSER_W-1:0]  in_user,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic [OUT_TUSER_W-1:0] out_user
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int LVL_W  = $clog2(LEVEL_COUNT);

  // latched operation
  mode_t                 op_mode;
  logic [LVL_W-1:0]      op_lvl;
  logic [DATA_WIDTH-1:0] op_word;

  // per-level lists and pool bookkeeping
  logic [SLOT_W-1:0] level_head  [LEVEL_COUNT];
  logic [SLOT_W-1:0] level_tail  [LEVEL_COUNT];
  logic [CNT_W-1:0]  level_count [LEVEL_COUNT];
  logic [CNT_W-1:0]  total, total_next;
  logic [CNT_W-1:0]  recycled;
  logic [CNT_W-1:0]  fresh;

  // memory ports
  logic                  pay_we, link_we, stk_we;
  logic [SLOT_W-1:0]     pay_waddr, link_waddr, stk_waddr;
  logic [SLOT_W-1:0]     link_wdata, stk_wdata;
  logic [SLOT_W-1:0]     head_raddr, stk_raddr;
  logic [DATA_WIDTH-1:0] pay_rdata;
  logic [SLOT_W-1:0]     link_rdata, stk_rdata;

  logic [LVL_W-1:0]  in_lvl, deq_lvl;
  logic [2:0]        in_prio;
  logic [CNT_W-1:0]  rc_dec;
  logic              is_full, is_empty, enq_go, deq_go;
  logic [SLOT_W-1:0] enq_slot;
  status_t           res_status;
  logic [WORD_W-1:0] res_data;

  // clamp the incoming level into range, 0 based
  always_comb begin
    in_prio = (in_data[PRIO_W-1:0] == '0) ? 3'd1 : {1'b0, in_data[PRIO_W-1:0]};
    if (int'(in_prio) > LEVEL_COUNT) begin
      in_lvl = LVL_W'(LEVEL_COUNT - 1);
    end else begin
      in_lvl = LVL_W'(in_prio - 3'd1);
    end
  end

  // highest non-empty level
  always_comb begin
    deq_lvl = '0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (level_count[i] != '0) begin
        deq_lvl = LVL_W'(i);
      end
    end
  end

  // read addresses follow the current state so the read data is ready in the cycle after accept
  assign rc_dec     = recycled - 1'b1;
  assign stk_raddr  = rc_dec[SLOT_W-1:0];
  assign head_raddr = level_head[deq_lvl];

  // decode of the pending operation
  assign is_full  = (total == CNT_W'(SLOT_COUNT));
  assign is_empty = (total == '0);
  assign enq_go   = (op_mode == MODE_ENQ) && !is_full;
  assign deq_go   = (op_mode == MODE_DEQ) && !is_empty;
  assign enq_slot = (recycled != '0) ? stk_rdata : fresh[SLOT_W-1:0];

  // memory writes at commit
  assign pay_we     = cmd.commit && enq_go;
  assign pay_waddr  = enq_slot;
  assign link_we    = cmd.commit && enq_go && (level_count[op_lvl] != '0);
  assign link_waddr = level_tail[op_lvl];
  assign link_wdata = enq_slot;
  assign stk_we     = cmd.commit && deq_go;
  assign stk_waddr  = recycled[SLOT_W-1:0];
  assign stk_wdata  = head_raddr;

  // result fields
  always_comb begin
    total_next = total;
    res_status = ST_OK;
    res_data   = '0;
    if (enq_go) begin
      total_next = total + 1'b1;
    end else if (deq_go) begin
      total_next = total - 1'b1;
      res_data   = WORD_W'(pay_rdata);
    end else if (op_mode == MODE_ENQ) begin
      res_status = ST_FULL;
    end else begin
      res_status = ST_EMPTY;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  // operation latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_mode <= mode_t'(in_user[0]);
      op_lvl  <= in_lvl;
      op_word <= DATA_WIDTH'(in_data[PRIO_W +: WORD_W]);
    end
  end

  // list and pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      recycled <= '0;
      fresh    <= '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        level_head[i]  <= '0;
        level_tail[i]  <= '0;
        level_count[i] <= '0;
      end
    end else if (cmd.commit) begin
      total <= total_next;
      if (enq_go) begin
        if (recycled != '0) begin
          recycled <= rc_dec;
        end else begin
          fresh <= fresh + 1'b1;
        end
        if (level_count[op_lvl] == '0) begin
          level_head[op_lvl] <= enq_slot;
        end
        level_tail[op_lvl]  <= enq_slot;
        level_count[op_lvl] <= level_count[op_lvl] + 1'b1;
      end else if (deq_go) begin
        recycled             <= recycled + 1'b1;
        level_count[deq_lvl] <= level_count[deq_lvl] - 1'b1;
        if (level_count[deq_lvl] == CNT_W'(1)) begin
          level_head[deq_lvl] <= '0;
          level_tail[deq_lvl] <= '0;
        end else begin
          level_head[deq_lvl] <= link_rdata;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= res_data;
      out_user <= {(total_next == '0), res_status, deq_go};
    end
  end

  // slot payloads
  tlpq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOT_COUNT)) u_payload (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (op_word),
    .raddr (head_raddr),
    .rdata (pay_rdata)
  );

  // next-slot links
  tlpq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (head_raddr),
    .rdata (link_rdata)
  );

  // stack of released slots
  tlpq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_free_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

// File: tb/three_level_priority_queue_core_tb.sv
module three_level_priority_queue_core_tb;
  import tlpq_pkg::*;

  localparam int SLOTS        = DEF_SLOT_COUNT;
  localparam int LEVELS       = DEF_LEVEL_COUNT;
  localparam int RANDOM_ITEMS = 950;
  localparam int TAIL_ITEMS   = 80;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 300;

  typedef struct {
    mode_t                mode;
    logic [PRIO_W-1:0]    level;
    logic [WORD_W-1:0]    word;
    bit                   drain_first;
  } stim_op_t;

  typedef struct {
    logic [WORD_W-1:0] out_data;
    logic              out_valid;
    status_t           status;
    logic              queue_empty;
  } queue_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  three_level_priority_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // stimulus and expected results
  stim_op_t      queued_ops[$];
  queue_result_t predicted_results[$];

  // shadow copy of the slot pool and the level lists
  logic [WORD_W-1:0] slot_payload[SLOTS];
  int                slot_next[SLOTS];
  int                free_stack[SLOTS];
  int                free_count;
  int                level_head[LEVELS];
  int                level_tail[LEVELS];
  int                level_items[LEVELS];

  int failures       = 0;
  int accepted_total = 0;
  int issued_total   = 0;
  int results_seen   = 0;
  int total_items    = 0;
  int enq_ops = 0, deq_ops = 0, full_hits = 0, empty_hits = 0;
  int occupancy = 0;
  bit pause_next = 1'b0;

  // apply one operation to the shadow pool and return its result
  function automatic queue_result_t pool_apply(input mode_t mode, input logic [PRIO_W-1:0] lvl_in,
                                               input logic [WORD_W-1:0] word);
    queue_result_t r;
    int lvl;
    int slot;
    r.out_data    = '0;
    r.out_valid   = 1'b0;
    r.status      = ST_OK;
    r.queue_empty = 1'b0;
    if (mode == MODE_ENQ) begin
      enq_ops++;
      if (free_count == 0) begin
        r.status = ST_FULL;
        full_hits++;
      end else begin
        // level zero maps to the top level, anything past the last to the last
        if (lvl_in == 0) lvl = 0;
        else if (int'(lvl_in) > LEVELS) lvl = LEVELS - 1;
        else lvl = int'(lvl_in) - 1;
        free_count--;
        slot = free_stack[free_count];
        slot_payload[slot] = word;
        slot_next[slot] = 0;
        if (level_items[lvl] == 0) level_head[lvl] = slot;
        else slot_next[level_tail[lvl]] = slot;
        level_tail[lvl] = slot;
        level_items[lvl]++;
      end
    end else begin
      deq_ops++;
      lvl = -1;
      for (int i = LEVELS - 1; i >= 0; i--)
        if (level_items[i] != 0) lvl = i;
      if (lvl < 0) begin
        r.status = ST_EMPTY;
        empty_hits++;
      end else begin
        slot = level_head[lvl];
        r.out_data  = slot_payload[slot];
        r.out_valid = 1'b1;
        level_items[lvl]--;
        if (level_items[lvl] == 0) begin
          level_head[lvl] = 0;
          level_tail[lvl] = 0;
        end else begin
          level_head[lvl] = slot_next[slot];
        end
        if (free_count < SLOTS) begin
          free_stack[free_count] = slot;
          free_count++;
        end
      end
    end
    r.queue_empty = (free_count >= SLOTS);
    return r;
  endfunction

  // queue one operation, tracking a rough occupancy to steer the phases
  task automatic push_op(input mode_t mode, input logic [PRIO_W-1:0] lvl,
                         input logic [WORD_W-1:0] word);
    stim_op_t op;
    op.mode        = mode;
    op.level       = lvl;
    op.word        = word;
    op.drain_first = pause_next;
    pause_next     = 1'b0;
    queued_ops.push_back(op);
    if (mode == MODE_ENQ) begin
      if (occupancy < SLOTS) occupancy++;
    end else if (occupancy > 0) begin
      occupancy--;
    end
  endtask

  task automatic push_random_op(input mode_t mode);
    logic [PRIO_W-1:0] lvl;
    logic [WORD_W-1:0] word;
    lvl = ($urandom_range(0, 7) == 0) ? 2'd0 : PRIO_W'($urandom_range(1, 3));
    case ($urandom_range(0, 9))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    push_op(mode, lvl, word);
  endtask

  // input side: acceptance and prediction; output side: comparison
  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predicted_results.push_back(pool_apply(mode_t'(s_tuser[0]), s_tdata[PRIO_W-1:0],
                                               s_tdata[PRIO_W+WORD_W-1:PRIO_W]));
        accepted_total++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.out_data    = m_tdata;
        got.out_valid   = m_tuser[0];
        got.status      = status_t'(m_tuser[2:1]);
        got.queue_empty = m_tuser[3];
        if (predicted_results.size() == 0) begin
          $error("result beat with nothing pending: data %h user %h", m_tdata, m_tuser);
          failures++;
        end else begin
          want = predicted_results.pop_front();
          if (got.out_data !== want.out_data) begin
            $error("out_data: expected %h actual %h", want.out_data, got.out_data);
            failures++;
          end
          if (got.out_valid !== want.out_valid) begin
            $error("out_valid: expected %0d actual %0d", want.out_valid, got.out_valid);
            failures++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status);
            failures++;
          end
          if (got.queue_empty !== want.queue_empty) begin
            $error("queue_empty: expected %0d actual %0d", want.queue_empty,
                   got.queue_empty);
            failures++;
          end
        end
      end
    end
  end

  // sender: offers queued operations with random gaps
  int send_gap = 0;
  int send_window = 0;
  bit send_may_idle = 1'b0;
  always @(negedge clk) begin
    logic                  nv;
    logic [IN_TDATA_W-1:0] nd;
    logic [IN_TUSER_W-1:0] nu;
    stim_op_t              op;
    if (!rst) begin
      nv = s_tvalid;
      nd = s_tdata;
      nu = s_tuser;
      if (s_tvalid && accepted_total == issued_total) nv = 1'b0;
      if (send_window == 0) begin
        send_window   = $urandom_range(20, 200);
        send_may_idle = ($urandom_range(0, 2) != 0);
      end else begin
        send_window--;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_ops.size() != 0) begin
          if (queued_ops[0].drain_first && predicted_results.size() != 0) begin
            // hold the next beat until every result has come back
          end else if (send_may_idle && queued_ops.size() > TAIL_ITEMS &&
                       $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(1, 17) - 1;
          end else begin
            op = queued_ops.pop_front();
            nv = 1'b1;
            nd = {{(IN_TDATA_W-WORD_W-PRIO_W){1'b0}}, op.word, op.level};
            nu = op.mode;
            issued_total++;
          end
        end
      end
      s_tvalid <= nv;
      s_tdata  <= nd;
      s_tuser  <= nu;
    end
  end

  // receiver: random stalls plus one long hold-off
  int recv_gap = 0;
  int recv_window = 0;
  bit recv_may_idle = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    logic nr;
    if (!rst) begin
      if (recv_window == 0) begin
        recv_window   = $urandom_range(20, 200);
        recv_may_idle = ($urandom_range(0, 2) != 0);
      end else begin
        recv_window--;
      end
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (!hold_done && accepted_total >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        nr = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        nr = 1'b0;
      end else if (recv_may_idle && accepted_total + TAIL_ITEMS < total_items &&
                   $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(1, 17) - 1;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      m_tready <= nr;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int pick;
    bit first_phase;
    for (int i = 0; i < SLOTS; i++) free_stack[i] = SLOTS - 1 - i;
    free_count = SLOTS;
    for (int i = 0; i < LEVELS; i++) begin
      level_head[i]  = 0;
      level_tail[i]  = 0;
      level_items[i] = 0;
    end

    // directed: every level, out of range level, data extremes, empty dequeue
    push_op(MODE_DEQ, 2'd3, 32'hFFFF_FFFF);
    push_op(MODE_ENQ, 2'd3, 32'hA5A5_5A5A);
    push_op(MODE_ENQ, 2'd2, 32'hFFFF_FFFF);
    push_op(MODE_ENQ, 2'd1, 32'h0000_0000);
    push_op(MODE_ENQ, 2'd0, 32'h1234_5678);
    push_op(MODE_ENQ, 2'd2, 32'h0F0F_0F0F);
    push_op(MODE_DEQ, 2'd0, 32'h0000_0000);
    push_op(MODE_DEQ, 2'd1, 32'h8000_0001);
    push_op(MODE_ENQ, 2'd1, 32'hDEAD_BEEF);
    push_op(MODE_DEQ, 2'd2, 32'h0000_0000);
    push_op(MODE_DEQ, 2'd3, 32'h7FFF_FFFF);
    push_op(MODE_DEQ, 2'd0, 32'h0000_0000);
    push_op(MODE_ENQ, 2'd3, 32'h0000_0001);
    push_op(MODE_DEQ, 2'd0, 32'h0000_0000);
    push_op(MODE_DEQ, 2'd0, 32'h0000_0000);
    push_op(MODE_DEQ, 2'd1, 32'hFFFF_FFFF);
    push_op(MODE_ENQ, 2'd1, 32'hFFFF_FFFF);
    push_op(MODE_DEQ, 2'd0, 32'h0000_0000);

    // random phases: fill to full, drain to empty, or a plain mix
    first_phase = 1'b1;
    while (queued_ops.size() < RANDOM_ITEMS + 18) begin
      pick = $urandom_range(0, 9);
      pause_next = first_phase || ($urandom_range(0, 2) == 0);
      first_phase = 1'b0;
      if (pick < 3) begin
        while (occupancy < SLOTS)
          push_random_op(($urandom_range(0, 6) == 0) ? MODE_DEQ : MODE_ENQ);
        repeat ($urandom_range(1, 3)) push_random_op(MODE_ENQ);
      end else if (pick < 6) begin
        while (occupancy > 0)
          push_random_op(($urandom_range(0, 6) == 0) ? MODE_ENQ : MODE_DEQ);
        repeat ($urandom_range(1, 2)) push_random_op(MODE_DEQ);
      end else begin
        repeat ($urandom_range(20, 60)) push_random_op(mode_t'($urandom_range(0, 1)));
      end
    end
    total_items = queued_ops.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every operation must have come back as a result
    wait (results_seen == total_items && predicted_results.size() == 0);
    repeat (10) @(posedge clk);
    $display("ran %0d operations (%0d enqueue, %0d dequeue), checked %0d results",
             accepted_total, enq_ops, deq_ops, results_seen);
    $display("enqueue into full pool %0d times, dequeue from empty queue %0d times",
             full_hits, empty_hits);
    if (failures == 0) begin
      $display("three_level_priority_queue_core test passed");
    end else begin
      $display("three_level_priority_queue_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("three_level_priority_queue_core test failed");
    $finish;
  end

endmodule
